>>> sv/fbm_value_noise_macros.svh
// ----------------------------------------------------------------------------
// fbm_value_noise assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef FBM_VALUE_NOISE_MACROS_SVH
`define FBM_VALUE_NOISE_MACROS_SVH

// same-cycle implication
`define FBMVN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FBMVN_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/fbmvn_pkg.sv
// ----------------------------------------------------------------------------
// fbmvn_pkg
// constants, register indexes and the lattice hash for the fbm noise block
// ----------------------------------------------------------------------------
package fbmvn_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_NOISE_SEED     = 3'd0;
    localparam logic [2:0] REG_OCTAVE_COUNT   = 3'd1;
    localparam logic [2:0] REG_BASE_FREQUENCY = 3'd2;
    localparam logic [2:0] REG_LACUNARITY     = 3'd3;
    localparam logic [2:0] REG_OCTAVE_GAIN    = 3'd4;
    localparam logic [2:0] REG_HEIGHT_SCALE   = 3'd5;

    // register reset values
    localparam logic [31:0] RST_NOISE_SEED     = 32'd0;
    localparam logic [3:0]  RST_OCTAVE_COUNT   = 4'd4;
    localparam logic [23:0] RST_BASE_FREQUENCY = 24'h010000;
    localparam logic [23:0] RST_LACUNARITY     = 24'h020000;
    localparam logic [23:0] RST_OCTAVE_GAIN    = 24'h008000;
    localparam logic [31:0] RST_HEIGHT_SCALE   = 32'h00010000;

    // fixed-point widths
    localparam int NOISE_W  = 24;
    localparam int WEIGHT_W = 56;

    // unity amplitude, Q16.16
    localparam logic [31:0] AMP_ONE = 32'h00010000;

    // hash constants
    localparam logic [31:0] WANG_XOR   = 32'd61;
    localparam logic [31:0] WANG_MUL   = 32'h27D4EB2D;
    localparam logic [31:0] HASH_X_OFS = 32'h45678901;
    localparam logic [31:0] HASH_Z_OFS = 32'h12345678;
    localparam int          SEED_STEP  = 31337;

    // smoothstep constant 3.0 in Q.16
    localparam logic [17:0] SMOOTH_THREE = 18'd196608;

    // integer mix hash
    function automatic logic [31:0] wang(input logic [31:0] n_in);
        logic [31:0] n;
        n = (n_in ^ WANG_XOR) ^ (n_in >> 16);
        n = n + (n << 3);
        n = n ^ (n >> 4);
        n = n * WANG_MUL;
        n = n ^ (n >> 15);
        return n;
    endfunction

endpackage

>>> sv/fbm_value_noise.sv
// ----------------------------------------------------------------------------
// fbm_value_noise
// fractal value-noise height for one (x, z) point per transfer
// ----------------------------------------------------------------------------
// Takes one point per clock while in_ready is high and returns one height
// per point, in order. Each octave runs in its own seven-stage pipeline, the
// octaves are summed by a registered adder tree of clog2(MAX_OCTAVES)+1
// stages, normalized by a 24-stage restoring divider (one quotient bit per
// stage) and scaled by a final multiply stage ahead of the output register.
// Per-octave frequencies, amplitudes and the total weight are rebuilt by a
// small sequencer after reset and after every register write; in_ready is
// low while it runs. When out_ready is low with a result held, the whole
// pipeline stalls.
// ----------------------------------------------------------------------------
`include "fbm_value_noise_macros.svh"

module fbm_value_noise
    import fbmvn_pkg::*;
#(
    parameter int MAX_OCTAVES = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] x_coord,
    input  logic [31:0] z_coord,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] height
);

    localparam int LEVELS    = $clog2(MAX_OCTAVES);
    localparam int LEAVES    = 1 << LEVELS;
    localparam int SUM_W     = WEIGHT_W + LEVELS;
    localparam int TOT_W     = 32 + LEVELS;
    localparam int IDX_W     = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int OCT_W     = $clog2(MAX_OCTAVES + 1);
    localparam int OCT_DEPTH = 7;
    localparam int PIPE_LEN  = OCT_DEPTH + LEVELS + 1 + NOISE_W + 1;
    localparam int DIV_LAST  = PIPE_LEN - 2;

    // configuration registers
    logic [31:0] noise_seed_reg;
    logic [3:0]  octave_count_reg;
    logic [23:0] base_frequency_reg;
    logic [23:0] lacunarity_reg;
    logic [23:0] octave_gain_reg;
    logic [31:0] height_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_seed_reg     <= RST_NOISE_SEED;
            octave_count_reg   <= RST_OCTAVE_COUNT;
            base_frequency_reg <= RST_BASE_FREQUENCY;
            lacunarity_reg     <= RST_LACUNARITY;
            octave_gain_reg    <= RST_OCTAVE_GAIN;
            height_scale_reg   <= RST_HEIGHT_SCALE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NOISE_SEED:     noise_seed_reg     <= cfg_data;
                REG_OCTAVE_COUNT:   octave_count_reg   <= cfg_data[3:0];
                REG_BASE_FREQUENCY: base_frequency_reg <= cfg_data[23:0];
                REG_LACUNARITY:     lacunarity_reg     <= cfg_data[23:0];
                REG_OCTAVE_GAIN:    octave_gain_reg    <= cfg_data[23:0];
                REG_HEIGHT_SCALE:   height_scale_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // clamped octave count
    logic [OCT_W-1:0] oct_eff;

    always_comb
    begin
        if (octave_count_reg == 4'd0)
            oct_eff = OCT_W'(1);
        else if (32'(octave_count_reg) > 32'(MAX_OCTAVES))
            oct_eff = OCT_W'(MAX_OCTAVES);
        else
            oct_eff = OCT_W'(octave_count_reg);
    end

    // octave table sequencer
    logic             restart_reg;
    logic             busy_reg;
    logic [IDX_W-1:0] seq_idx_reg;
    logic [31:0]      f_run_reg;
    logic [31:0]      a_run_reg;
    logic [TOT_W-1:0] total_reg;
    logic [31:0]      freq_tab_reg [0:MAX_OCTAVES-1];
    logic [31:0]      amp_tab_reg  [0:MAX_OCTAVES-1];
    logic [55:0]      f_prod;
    logic [55:0]      a_prod;
    logic [31:0]      f_next;
    logic [31:0]      a_next;

    assign f_prod = f_run_reg * lacunarity_reg;
    assign a_prod = a_run_reg * octave_gain_reg;
    assign f_next = (|f_prod[55:48]) ? 32'hFFFFFFFF : f_prod[47:16];
    assign a_next = (|a_prod[55:48]) ? 32'hFFFFFFFF : a_prod[47:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_reg <= 1'b1;
            busy_reg    <= 1'b0;
            seq_idx_reg <= '0;
        end
        else
        begin
            restart_reg <= cfg_we;
            if (restart_reg)
            begin
                busy_reg    <= 1'b1;
                seq_idx_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (seq_idx_reg == IDX_W'(MAX_OCTAVES - 1))
                    busy_reg <= 1'b0;
                else
                    seq_idx_reg <= seq_idx_reg + 1'b1;
            end
        end
    end

    // running frequency, amplitude and total weight
    always_ff @(posedge clk)
    begin
        if (restart_reg)
        begin
            f_run_reg <= {8'b0, base_frequency_reg};
            a_run_reg <= AMP_ONE;
            total_reg <= '0;
        end
        else if (busy_reg)
        begin
            freq_tab_reg[seq_idx_reg] <= f_run_reg;
            amp_tab_reg[seq_idx_reg]  <= a_run_reg;
            if (OCT_W'(seq_idx_reg) < oct_eff)
                total_reg <= total_reg + TOT_W'(a_run_reg);
            f_run_reg <= f_next;
            a_run_reg <= a_next;
        end
    end

    // pipeline enable and valid chain
    logic                en;
    logic                out_valid_reg;
    logic [PIPE_LEN-1:0] vld_reg;

    assign en       = ~out_valid_reg | out_ready;
    assign in_ready = en & ~busy_reg & ~restart_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LEN-2:0], in_valid & in_ready};
    end

    // octave pipelines and masked tree leaves
    logic [WEIGHT_W-1:0] weighted [0:MAX_OCTAVES-1];
    logic [SUM_W-1:0]    tree_reg [0:LEVELS][0:LEAVES-1];

    for (genvar i = 0; i < LEAVES; i++)
    begin : g_oct
        if (i < MAX_OCTAVES)
        begin : g_on
            logic [31:0] oct_seed;
            logic        oct_on;

            assign oct_seed = noise_seed_reg + 32'(i * SEED_STEP);
            assign oct_on   = OCT_W'(i) < oct_eff;

            fbmvn_octave u_octave (
                .clk      (clk),
                .en       (en),
                .x_coord  (x_coord),
                .z_coord  (z_coord),
                .freq     (freq_tab_reg[i]),
                .amp      (amp_tab_reg[i]),
                .seed     (oct_seed),
                .weighted (weighted[i])
            );

            always_ff @(posedge clk)
            begin
                if (en)
                    tree_reg[0][i] <= oct_on ? SUM_W'(weighted[i]) : '0;
            end
        end
        else
        begin : g_pad
            always_ff @(posedge clk)
            begin
                if (en)
                    tree_reg[0][i] <= '0;
            end
        end
    end

    // registered adder tree
    for (genvar l = 0; l < LEVELS; l++)
    begin : g_lvl
        for (genvar j = 0; j < LEAVES; j++)
        begin : g_node
            if (j < (LEAVES >> (l + 1)))
            begin : g_add
                always_ff @(posedge clk)
                begin
                    if (en)
                        tree_reg[l+1][j] <= tree_reg[l][2*j] + tree_reg[l][2*j+1];
                end
            end
            else
            begin : g_zero
                always_ff @(posedge clk)
                begin
                    if (en)
                        tree_reg[l+1][j] <= '0;
                end
            end
        end
    end

    // restoring divider, one quotient bit per stage
    logic [TOT_W-1:0]   div_rem_reg [0:NOISE_W-1];
    logic [NOISE_W-1:0] div_low_reg [0:NOISE_W-1];
    logic [NOISE_W-1:0] div_q_reg   [0:NOISE_W-1];

    for (genvar k = 0; k < NOISE_W; k++)
    begin : g_div
        logic [TOT_W-1:0]   rem_in;
        logic [NOISE_W-1:0] low_in;
        logic [NOISE_W-1:0] q_in;
        logic [TOT_W:0]     trial;
        logic [TOT_W:0]     diff;

        if (k == 0)
        begin : g_first
            assign rem_in = tree_reg[LEVELS][0][SUM_W-1:NOISE_W];
            assign low_in = tree_reg[LEVELS][0][NOISE_W-1:0];
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = div_rem_reg[k-1];
            assign low_in = div_low_reg[k-1];
            assign q_in   = div_q_reg[k-1];
        end

        assign trial = {rem_in, low_in[NOISE_W-1]};
        assign diff  = trial - {1'b0, total_reg};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= {1'b0, total_reg})
                begin
                    div_rem_reg[k] <= diff[TOT_W-1:0];
                    div_q_reg[k]   <= {q_in[NOISE_W-2:0], 1'b1};
                end
                else
                begin
                    div_rem_reg[k] <= trial[TOT_W-1:0];
                    div_q_reg[k]   <= {q_in[NOISE_W-2:0], 1'b0};
                end
                div_low_reg[k] <= {low_in[NOISE_W-2:0], 1'b0};
            end
        end
    end

    // height scaling
    logic signed [56:0] mult_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            mult_reg <= $signed({1'b0, div_q_reg[NOISE_W-1]}) * $signed(height_scale_reg);
    end

    // output register
    logic [31:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_reg[PIPE_LEN-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            height_reg <= (noise_seed_reg == '0) ? 32'd0 : mult_reg[55:24];
    end

    assign out_valid = out_valid_reg;
    assign height    = height_reg;

    // checks
    `FBMVN_ASSERT_NXT(a_cfg_blocks_input, cfg_we, !in_ready, "input taken right after a register write")
    `FBMVN_ASSERT_NXT(a_restart_seq, restart_reg, busy_reg && (seq_idx_reg == '0), "table rebuild did not start")
    `FBMVN_ASSERT_IMP(a_div_rem_bound, vld_reg[DIV_LAST], div_rem_reg[NOISE_W-1] < total_reg, "divider remainder not below total weight")

endmodule

>>> sv/fbmvn_octave.sv
// ----------------------------------------------------------------------------
// fbmvn_octave
// one octave of bilinear value noise, seven register stages, weighted output
// ----------------------------------------------------------------------------
module fbmvn_octave
    import fbmvn_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [31:0]         x_coord,
    input  logic [31:0]         z_coord,
    input  logic [31:0]         freq,
    input  logic [31:0]         amp,
    input  logic [31:0]         seed,
    output logic [WEIGHT_W-1:0] weighted
);

    // stage 1: scaled point, Q32.32
    logic signed [64:0] px_full;
    logic signed [64:0] pz_full;
    logic [63:0]        px_reg;
    logic [63:0]        pz_reg;

    assign px_full = $signed(x_coord) * $signed({1'b0, freq});
    assign pz_full = $signed(z_coord) * $signed({1'b0, freq});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_full[63:0];
            pz_reg <= pz_full[63:0];
        end
    end

    // stage 2: row hashes and squared fractions
    logic [31:0] ix_s2_reg;
    logic [31:0] hz0_reg;
    logic [31:0] hz1_reg;
    logic [15:0] tx_s2_reg;
    logic [15:0] tz_s2_reg;
    logic [15:0] sx_reg;
    logic [15:0] sz_reg;
    logic [31:0] tx_sq;
    logic [31:0] tz_sq;

    assign tx_sq = px_reg[31:16] * px_reg[31:16];
    assign tz_sq = pz_reg[31:16] * pz_reg[31:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ix_s2_reg <= px_reg[63:32];
            hz0_reg   <= wang(pz_reg[63:32] + HASH_Z_OFS);
            hz1_reg   <= wang(pz_reg[63:32] + 32'd1 + HASH_Z_OFS);
            tx_s2_reg <= px_reg[31:16];
            tz_s2_reg <= pz_reg[31:16];
            sx_reg    <= tx_sq[31:16];
            sz_reg    <= tz_sq[31:16];
        end
    end

    // stage 3: column hashes and smoothstep weights
    logic [31:0] h00_reg;
    logic [31:0] h10_reg;
    logic [31:0] h01_reg;
    logic [31:0] h11_reg;
    logic [15:0] ux_s3_reg;
    logic [15:0] uz_s3_reg;
    logic [31:0] hx0;
    logic [31:0] hx1;
    logic [17:0] wx;
    logic [17:0] wz;
    logic [33:0] ux_full;
    logic [33:0] uz_full;

    assign hx0     = ix_s2_reg + HASH_X_OFS;
    assign hx1     = ix_s2_reg + 32'd1 + HASH_X_OFS;
    assign wx      = SMOOTH_THREE - {1'b0, tx_s2_reg, 1'b0};
    assign wz      = SMOOTH_THREE - {1'b0, tz_s2_reg, 1'b0};
    assign ux_full = sx_reg * wx;
    assign uz_full = sz_reg * wz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h00_reg   <= wang(hx0 ^ hz0_reg);
            h10_reg   <= wang(hx1 ^ hz0_reg);
            h01_reg   <= wang(hx0 ^ hz1_reg);
            h11_reg   <= wang(hx1 ^ hz1_reg);
            ux_s3_reg <= ux_full[31:16];
            uz_s3_reg <= uz_full[31:16];
        end
    end

    // stage 4: seeded corner values
    logic [31:0]        v00_full;
    logic [31:0]        v10_full;
    logic [31:0]        v01_full;
    logic [31:0]        v11_full;
    logic [NOISE_W-1:0] v00_reg;
    logic [NOISE_W-1:0] v10_reg;
    logic [NOISE_W-1:0] v01_reg;
    logic [NOISE_W-1:0] v11_reg;
    logic [15:0]        ux_s4_reg;
    logic [15:0]        uz_s4_reg;

    assign v00_full = wang(seed ^ h00_reg);
    assign v10_full = wang(seed ^ h10_reg);
    assign v01_full = wang(seed ^ h01_reg);
    assign v11_full = wang(seed ^ h11_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v00_reg   <= v00_full[NOISE_W-1:0];
            v10_reg   <= v10_full[NOISE_W-1:0];
            v01_reg   <= v01_full[NOISE_W-1:0];
            v11_reg   <= v11_full[NOISE_W-1:0];
            ux_s4_reg <= ux_s3_reg;
            uz_s4_reg <= uz_s3_reg;
        end
    end

    // stage 5: blend along x
    logic signed [25:0] d10;
    logic signed [25:0] d01;
    logic signed [26:0] dd;
    logic signed [16:0] ux_s;
    logic signed [42:0] dx_prod;
    logic signed [43:0] ddx_prod;
    logic signed [43:0] a_next;
    logic signed [44:0] b_next;
    logic signed [43:0] a_reg;
    logic signed [44:0] b_reg;
    logic [15:0]        uz_s5_reg;

    assign ux_s     = $signed({1'b0, ux_s4_reg});
    assign d10      = $signed({2'b0, v10_reg}) - $signed({2'b0, v00_reg});
    assign d01      = $signed({2'b0, v01_reg}) - $signed({2'b0, v00_reg});
    assign dd       = $signed({3'b0, v00_reg}) - $signed({3'b0, v10_reg})
                    - $signed({3'b0, v01_reg}) + $signed({3'b0, v11_reg});
    // full-width products of the corner differences and the x weight
    assign dx_prod  = d10 * ux_s;
    assign ddx_prod = dd * ux_s;
    assign a_next   = $signed({4'b0, v00_reg, 16'b0}) + 44'(dx_prod);
    assign b_next   = (45'(d01) <<< 16) + 45'(ddx_prod);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            uz_s5_reg <= uz_s4_reg;
        end
    end

    // stage 6: blend along z, floor to Q0.24
    logic signed [16:0] uz_s;
    logic signed [61:0] bz_prod;
    logic signed [61:0] n_full;
    logic [NOISE_W-1:0] noise_reg;

    assign uz_s    = $signed({1'b0, uz_s5_reg});
    assign bz_prod = b_reg * uz_s;
    assign n_full  = (62'(a_reg) <<< 16) + bz_prod;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            noise_reg <= n_full[61] ? '0 : n_full[55:32];
        end
    end

    // stage 7: octave weight
    logic [WEIGHT_W-1:0] weighted_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            weighted_reg <= amp * noise_reg;
        end
    end

    assign weighted = weighted_reg;

endmodule

>>> sim/fbm_value_noise_tb.sv
// ----------------------------------------------------------------------------
// fbm_value_noise_tb
// self-checking testbench for the fractal value-noise height block
// ----------------------------------------------------------------------------
// Runs the block through a series of register settings, extremes included.
// Under each setting it streams points through the block, with bursty input
// and a receiver that stalls now and then. A software predictor computes each
// height from the point and the settings, and the heights that come back are
// checked in order against it.
// ----------------------------------------------------------------------------
module fbm_value_noise_tb;
    import fbmvn_pkg::*;

    localparam int OCTAVE_LIMIT = 12;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] z;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] x_coord;
    logic [31:0] z_coord;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] height;

    // settings as the predictor sees them
    logic [31:0] seed_q;
    logic [3:0]  octaves_q;
    logic [23:0] base_freq_q;
    logic [23:0] lacunarity_q;
    logic [23:0] gain_q;
    logic [31:0] scale_q;

    point_t      pending_points[$];
    logic [31:0] expected_heights[$];
    int          mismatch_count;
    int          error_count;
    logic        hold_input;
    logic        long_stall_req;
    logic        long_stall_ack;

    fbm_value_noise dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_coord   (x_coord),
        .z_coord   (z_coord),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .height    (height)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = ~clk;
    end

    // integer mix used for lattice corner values
    function automatic logic [31:0] mix32(input logic [31:0] v);
        logic [31:0] n;
        n = (v ^ 32'd61) ^ (v >> 16);
        n = n + (n << 3);
        n = n ^ (n >> 4);
        n = n * 32'h27D4EB2D;
        n = n ^ (n >> 15);
        return n;
    endfunction

    function automatic longint lattice_value(input logic [31:0] seed,
                                             input logic [31:0] ix,
                                             input logic [31:0] iz);
        logic [31:0] h;
        h = mix32(iz + 32'h12345678);
        h = mix32((ix + 32'h45678901) ^ h);
        h = mix32(seed ^ h);
        return longint'({40'd0, h[23:0]});
    endfunction

    // cubic fade of a 16-bit fraction
    function automatic longint fade(input logic [15:0] t);
        logic [63:0] s;
        logic [63:0] w;
        s = (64'(t) * 64'(t)) >> 16;
        w = 64'd196608 - 2 * 64'(t);
        return longint'((s * w) >> 16);
    endfunction

    // one octave of bilinear value noise, Q0.24
    function automatic logic [63:0] octave_noise(input logic [31:0] seed,
                                                 input logic [31:0] x,
                                                 input logic [31:0] z,
                                                 input logic [31:0] f);
        logic [63:0] px;
        logic [63:0] pz;
        longint      ux;
        longint      uz;
        longint      v00;
        longint      v10;
        longint      v01;
        longint      v11;
        longint      a;
        longint      b;
        longint      n;
        px = $signed({{32{x[31]}}, x}) * $signed({32'd0, f});
        pz = $signed({{32{z[31]}}, z}) * $signed({32'd0, f});
        ux = fade(px[31:16]);
        uz = fade(pz[31:16]);
        v00 = lattice_value(seed, px[63:32], pz[63:32]);
        v10 = lattice_value(seed, px[63:32] + 32'd1, pz[63:32]);
        v01 = lattice_value(seed, px[63:32], pz[63:32] + 32'd1);
        v11 = lattice_value(seed, px[63:32] + 32'd1, pz[63:32] + 32'd1);
        a = v00 * 65536 + (v10 - v00) * ux;
        b = (v01 - v00) * 65536 + (v00 - v10 - v01 + v11) * ux;
        n = a * 65536 + b * uz;
        if (n < 0)
        begin
            n = 0;
        end
        return 64'(n) >> 32;
    endfunction

    // full fractal height for one point under the current settings
    function automatic logic [31:0] predict_height(input logic [31:0] x,
                                                   input logic [31:0] z);
        int          oct;
        logic [63:0] sum;
        logic [63:0] total;
        logic [63:0] f;
        logic [63:0] amp;
        logic [63:0] norm;
        logic [63:0] mag;
        logic [63:0] hm;
        logic [31:0] neg_scale;
        longint      res;
        if (seed_q == 32'd0)
        begin
            return 32'd0;
        end
        oct = int'(octaves_q);
        if (oct < 1)
        begin
            oct = 1;
        end
        if (oct > OCTAVE_LIMIT)
        begin
            oct = OCTAVE_LIMIT;
        end
        sum = 0;
        total = 0;
        f = 64'(base_freq_q);
        amp = 64'h10000;
        for (int i = 0; i < oct; i++)
        begin
            sum = sum + amp * octave_noise(seed_q + 32'(i) * 32'd31337, x, z, f[31:0]);
            total = total + amp;
            f = (f * 64'(lacunarity_q)) >> 16;
            if (f > 64'hFFFFFFFF)
            begin
                f = 64'hFFFFFFFF;
            end
            amp = (amp * 64'(gain_q)) >> 16;
            if (amp > 64'hFFFFFFFF)
            begin
                amp = 64'hFFFFFFFF;
            end
        end
        if (total == 0)
        begin
            return 32'd0;
        end
        norm = sum / total;
        // magnitude of the scale, negated in 32 bits
        neg_scale = ~scale_q + 32'd1;
        mag = scale_q[31] ? 64'(neg_scale) : 64'(scale_q);
        hm = norm * mag;
        if (scale_q[31])
        begin
            res = -longint'((hm + 64'hFFFFFF) >> 24);
        end
        else
        begin
            res = longint'(hm >> 24);
        end
        if (res > 64'sd2147483647)
        begin
            res = 64'sd2147483647;
        end
        if (res < -64'sd2147483648)
        begin
            res = -64'sd2147483648;
        end
        return res[31:0];
    endfunction

    // sender: bursts of transfers with random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            x_coord    <= 32'd0;
            z_coord    <= 32'd0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_points.size() > 0 && !hold_input)
            begin
                point_t p;
                p = pending_points.pop_front();
                in_valid <= 1'b1;
                x_coord  <= p.x;
                z_coord  <= p.z;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern that is redrawn periodically, plus long hold-off
    int ready_pct;
    int pattern_cnt;
    int long_stall_cnt;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            ready_pct      <= 100;
            pattern_cnt    <= 0;
            long_stall_cnt <= 0;
            long_stall_ack <= 1'b0;
        end
        else
        begin
            pattern_cnt <= pattern_cnt + 1;
            if (pattern_cnt % 64 == 63)
            begin
                case ($urandom_range(0, 3))
                    0: ready_pct <= 100;
                    1: ready_pct <= 80;
                    2: ready_pct <= 50;
                    default: ready_pct <= 20;
                endcase
            end
            if (long_stall_req != long_stall_ack)
            begin
                long_stall_ack <= long_stall_req;
                long_stall_cnt <= 500;
                out_ready      <= 1'b0;
            end
            else if (long_stall_cnt > 0)
            begin
                long_stall_cnt <= long_stall_cnt - 1;
                out_ready      <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // monitor: check results, then predict for each accepted point
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_heights.size() == 0)
                begin
                    error_count++;
                    $display("unexpected height transfer: %h", height);
                end
                else
                begin
                    logic [31:0] want;
                    want = expected_heights.pop_front();
                    if (height !== want)
                    begin
                        error_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("height mismatch: expected %h actual %h", want, height);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_heights.insert(expected_heights.size(),
                                        predict_height(x_coord, z_coord));
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_NOISE_SEED:     seed_q = value;
            REG_OCTAVE_COUNT:   octaves_q = value[3:0];
            REG_BASE_FREQUENCY: base_freq_q = value[23:0];
            REG_LACUNARITY:     lacunarity_q = value[23:0];
            REG_OCTAVE_GAIN:    gain_q = value[23:0];
            REG_HEIGHT_SCALE:   scale_q = value;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] seed, input logic [3:0] oct,
                             input logic [23:0] freq, input logic [23:0] lac,
                             input logic [23:0] gain, input logic [31:0] scale);
        write_reg(REG_NOISE_SEED, seed);
        write_reg(REG_OCTAVE_COUNT, 32'(oct));
        write_reg(REG_BASE_FREQUENCY, 32'(freq));
        write_reg(REG_LACUNARITY, 32'(lac));
        write_reg(REG_OCTAVE_GAIN, 32'(gain));
        write_reg(REG_HEIGHT_SCALE, scale);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every point went in and every height came back
    task automatic wait_idle();
        @(negedge clk);
        while (pending_points.size() > 0 || in_valid || expected_heights.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000);
            2: return $urandom_range(0, 32'hFFFF);
            3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($urandom_range(0, 7) * 32'h40000000 + $urandom_range(0, 3) - 2);
        endcase
    endfunction

    function automatic logic [23:0] random_q816();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 24'h40000));
            1: return 24'($urandom());
            2: return 24'($urandom_range(24'h8000, 24'h28000));
            default: return 24'($urandom_range(0, 24'h1000));
        endcase
    endfunction

    initial
    begin
        logic [31:0] corner_vals[8];
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_NOISE_SEED;
        cfg_data       = 32'd0;
        hold_input     = 1'b0;
        long_stall_req = 1'b0;
        mismatch_count = 0;
        error_count    = 0;
        seed_q         = RST_NOISE_SEED;
        octaves_q      = RST_OCTAVE_COUNT;
        base_freq_q    = RST_BASE_FREQUENCY;
        lacunarity_q   = RST_LACUNARITY;
        gain_q         = RST_OCTAVE_GAIN;
        scale_q        = RST_HEIGHT_SCALE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero seed gives flat terrain
        for (int i = 0; i < 3; i++)
        begin
            pending_points.insert(pending_points.size(), point_t'{$urandom(), $urandom()});
        end
        wait_idle();

        // coordinate extremes and lattice wrap, first with every octave used, then with a zero octave count
        corner_vals = '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                        32'h0000FFFF, 32'h00010000, 32'h7FFF0000, 32'h80000001};
        write_all(32'h1234_5678, 4'd15, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'h7FFFFFFF);
        for (int i = 0; i < 8; i++)
        begin
            pending_points.insert(pending_points.size(),
                                  point_t'{corner_vals[i], corner_vals[7 - i]});
        end
        wait_idle();
        write_all(32'h80000000, 4'd0, 24'h010000, 24'h000000, 24'h000000, 32'h80000000);
        for (int i = 0; i < 8; i++)
        begin
            pending_points.insert(pending_points.size(),
                                  point_t'{corner_vals[(i + 3) % 8], corner_vals[i]});
        end
        wait_idle();

        // random phases over many settings
        for (int phase = 0; phase < 14; phase++)
        begin
            logic [31:0] seed;
            logic [3:0]  oct;
            logic [31:0] scale;
            seed  = $urandom();
            oct   = 4'($urandom_range(0, 15));
            scale = $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h80000)) : $urandom();
            case (phase)
                0: write_all(32'hFFFFFFFF, 4'd12, 24'h010000, 24'h020000, 24'h008000,
                             32'h7FFFFFFF);
                1: write_all(seed, 4'd13, 24'h000000, 24'hFFFFFF, 24'h010000, 32'h80000000);
                2: write_all(seed, 4'd1, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 32'hFFFFFFFF);
                3: write_all(32'd0, oct, random_q816(), random_q816(), random_q816(), scale);
                default: write_all(seed, oct, random_q816(), random_q816(), random_q816(),
                                   scale);
            endcase
            // long receiver hold-off while the sender keeps offering
            if (phase == 5)
            begin
                long_stall_req = ~long_stall_req;
            end
            for (int i = 0; i < 88; i++)
            begin
                pending_points.insert(pending_points.size(),
                                      point_t'{random_coord(), random_coord()});
            end
            wait_idle();
        end

        if (error_count == 0)
        begin
            $display("fbm_value_noise test passed");
        end
        else
        begin
            $display("fbm_value_noise test failed");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("fbm_value_noise test failed");
        $finish;
    end

endmodule
